// ===== src/gsm7u_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character tables for the GSM 7-bit text unpacker.
// No dependencies; imported by every module of the block.
package gsm7u_pkg;

    localparam logic [6:0] ESCAPE_SEPTET  = 7'h1B;
    localparam logic [6:0] PADDING_SEPTET = 7'h00;
    localparam logic [2:0] LAST_PHASE     = 3'd6;
    localparam logic [15:0] SPACE_CODE    = 16'h0020;

    // How the back end maps a septet
    typedef enum logic [1:0] {
        KIND_DEFAULT = 2'd0,
        KIND_EXT     = 2'd1,
        KIND_SPACE   = 2'd2
    } gsm7u_kind_t;

    // One queue word: the characters produced by one packed byte
    typedef struct packed {
        logic [6:0]  sept0;
        gsm7u_kind_t kind0;
        logic [6:0]  sept1;
        gsm7u_kind_t kind1;
        logic [1:0]  count;      // 0 means an empty end marker
        logic        final_flag;
    } gsm7u_entry_t;

    localparam logic [15:0] LOW_CHARS [32] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'hFFFF, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9
    };

    // Default alphabet
    function automatic logic [15:0] default_char(input logic [6:0] s);
        logic [15:0] code;
        case (s) inside
            [7'h00:7'h1F]: code = LOW_CHARS[s[4:0]];
            7'h24:         code = 16'h00A4;
            7'h40:         code = 16'h00A1;
            7'h5B:         code = 16'h00C4;
            7'h5C:         code = 16'h00D6;
            7'h5D:         code = 16'h00D1;
            7'h5E:         code = 16'h00DC;
            7'h5F:         code = 16'h00A7;
            7'h60:         code = 16'h00BF;
            7'h7B:         code = 16'h00E4;
            7'h7C:         code = 16'h00F6;
            7'h7D:         code = 16'h00F1;
            7'h7E:         code = 16'h00FC;
            7'h7F:         code = 16'h00E0;
            default:       code = {9'd0, s};
        endcase
        return code;
    endfunction

    // Extension table; zero marks a blank entry
    function automatic logic [15:0] ext_char(input logic [6:0] s);
        logic [15:0] code;
        case (s)
            7'h0A:   code = 16'h000C;
            7'h14:   code = 16'h005E;
            7'h28:   code = 16'h007B;
            7'h29:   code = 16'h007D;
            7'h2F:   code = 16'h005C;
            7'h3C:   code = 16'h005B;
            7'h3D:   code = 16'h007E;
            7'h3E:   code = 16'h005D;
            7'h40:   code = 16'h007C;
            7'h65:   code = 16'h20AC;
            default: code = 16'h0000;
        endcase
        return code;
    endfunction

endpackage

// ===== src/gsm7u_front.sv =====
`timescale 1ns / 1ps
// Front end: takes packed bytes, cuts septets, tracks escapes and padding, and pushes
// one classified word for each byte that gives a character or closes a message.
// Uses gsm7u_pkg.
module gsm7u_front
    import gsm7u_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   packed_byte,
    input  logic         final_byte,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         fifo_full,
    output logic         push_valid,
    output gsm7u_entry_t push_entry
);

    logic [5:0]  bit_store_reg, bit_store_next;
    logic [2:0]  bits_held_reg, bits_held_next;
    logic        escape_pending_reg, escape_pending_next;

    logic        accept;
    logic [13:0] store_w;
    logic [6:0]  s0, s1;
    logic        two_septets;
    logic        emit0, emit1, esc_mid, esc_end;
    gsm7u_kind_t kind0, kind1;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    // Join leftover bits with the new byte, oldest bit at the bottom
    assign store_w     = {8'd0, bit_store_reg} | ({6'd0, packed_byte} << bits_held_reg);
    assign s0          = store_w[6:0];
    assign s1          = store_w[13:7];
    assign two_septets = (bits_held_reg == LAST_PHASE);

    // Escape handling over the one or two septets of this byte
    always_comb
    begin
        emit0   = 1'b1;
        kind0   = KIND_DEFAULT;
        esc_mid = 1'b0;
        if (escape_pending_reg)
        begin
            kind0 = (s0 == ESCAPE_SEPTET) ? KIND_SPACE : KIND_EXT;
        end
        else if (s0 == ESCAPE_SEPTET)
        begin
            emit0   = 1'b0;
            esc_mid = 1'b1;
        end

        emit1   = 1'b0;
        kind1   = KIND_DEFAULT;
        esc_end = esc_mid;
        // second septet, unless it is the padding septet at the end
        if (two_septets && !(final_byte && s1 == PADDING_SEPTET))
        begin
            emit1   = 1'b1;
            esc_end = 1'b0;
            if (esc_mid)
            begin
                kind1 = (s1 == ESCAPE_SEPTET) ? KIND_SPACE : KIND_EXT;
            end
            else if (s1 == ESCAPE_SEPTET)
            begin
                emit1   = 1'b0;
                esc_end = 1'b1;
            end
        end
    end

    // Pack characters into the low slot first
    always_comb
    begin
        push_entry.final_flag = final_byte;
        push_entry.count      = {1'b0, emit0} + {1'b0, emit1};
        if (emit0)
        begin
            push_entry.sept0 = s0;
            push_entry.kind0 = kind0;
        end
        else
        begin
            push_entry.sept0 = s1;
            push_entry.kind0 = kind1;
        end
        push_entry.sept1 = s1;
        push_entry.kind1 = kind1;
    end

    assign push_valid = accept && (emit0 || emit1 || final_byte);

    // Stream state; the end of a message returns it to reset values
    always_comb
    begin
        bit_store_next      = bit_store_reg;
        bits_held_next      = bits_held_reg;
        escape_pending_next = escape_pending_reg;
        if (accept)
        begin
            if (final_byte)
            begin
                bit_store_next      = '0;
                bits_held_next      = '0;
                escape_pending_next = 1'b0;
            end
            else
            begin
                bit_store_next      = two_septets ? 6'd0 : store_w[12:7];
                bits_held_next      = two_septets ? 3'd0 : bits_held_reg + 3'd1;
                escape_pending_next = esc_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_store_reg      <= '0;
            bits_held_reg      <= '0;
            escape_pending_reg <= 1'b0;
        end
        else
        begin
            bit_store_reg      <= bit_store_next;
            bits_held_reg      <= bits_held_next;
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

// ===== src/gsm7u_fifo.sv =====
`timescale 1ns / 1ps
// Two-word queue between the front and back ends.
// Uses gsm7u_pkg for the word layout.
module gsm7u_fifo
    import gsm7u_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  gsm7u_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output gsm7u_entry_t head_entry
);

    gsm7u_entry_t slots_reg [2];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slots_reg[rptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/gsm7u_back.sv =====
`timescale 1ns / 1ps
// Back end: maps queued septets to code points and drives the output register,
// one word per cycle unless out_ready stalls it; gsm7u_pkg gives tables and layout.
module gsm7u_back
    import gsm7u_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  gsm7u_entry_t head_entry,
    output logic         pop,
    output logic [15:0]  char_code,
    output logic         has_char,
    output logic         end_of_message,
    output logic         last_in_run,
    output logic         out_valid,
    input  logic         out_ready
);

    logic        out_valid_reg, out_valid_next;
    logic [15:0] char_code_reg;
    logic        has_char_reg, end_of_message_reg, last_in_run_reg;
    logic        sub_reg, sub_next;

    logic        emit, is_last, is_marker;
    logic [6:0]  sel_sept;
    gsm7u_kind_t sel_kind;
    logic [15:0] ext_code, map_code;

    assign is_marker = (head_entry.count == 2'd0);
    assign is_last   = (head_entry.count != 2'd2) || sub_reg;
    assign emit      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = emit && is_last;

    // Character lookup for the current slot
    assign sel_sept = sub_reg ? head_entry.sept1 : head_entry.sept0;
    assign sel_kind = sub_reg ? head_entry.kind1 : head_entry.kind0;
    assign ext_code = ext_char(sel_sept);

    always_comb
    begin
        case (sel_kind)
            KIND_SPACE: map_code = SPACE_CODE;
            KIND_EXT:   map_code = (ext_code != 16'h0000) ? ext_code
                                                          : default_char(sel_sept);
            default:    map_code = default_char(sel_sept);
        endcase
    end

    always_comb
    begin
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            sub_next       = !is_last;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_code_reg      <= is_marker ? 16'h0000 : map_code;
            has_char_reg       <= !is_marker;
            end_of_message_reg <= is_last && head_entry.final_flag;
            last_in_run_reg    <= is_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign char_code      = char_code_reg;
    assign has_char       = has_char_reg;
    assign end_of_message = end_of_message_reg;
    assign last_in_run    = last_in_run_reg;

    // An empty word only ever closes a message
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !has_char_reg |-> end_of_message_reg && last_in_run_reg)
        else $error("empty word without end of message");

    a_eom_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_of_message_reg |-> last_in_run_reg)
        else $error("end of message not on last word of a byte");

    // Half-way through a two-character byte, its queue word must still be there
    a_second_slot_held: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> head_valid && head_entry.count == 2'd2)
        else $error("second character pending without a queue word");

endmodule

// ===== src/gsm7_packed_text_unpacker.sv =====
`timescale 1ns / 1ps
// GSM 7-bit packed text unpacker. One packed byte is taken per cycle while the
// two-word queue behind the front end has room; each byte gives zero, one or two
// 16-bit code points, and the back end delivers one word per cycle from its
// output register while out_ready does not stall it. The sustained byte rate is
// set by the single output register of the back end. The end of a message
// clears leftover bits and any pending escape. Uses gsm7u_pkg.
module gsm7_packed_text_unpacker
    import gsm7u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  packed_byte,
    input  logic        final_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [15:0] char_code,
    output logic        has_char,
    output logic        end_of_message,
    output logic        last_in_run,
    output logic        out_valid,
    input  logic        out_ready
);

    logic         fifo_full, push_valid, head_valid, pop;
    gsm7u_entry_t push_entry, head_entry;

    gsm7u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .packed_byte(packed_byte),
        .final_byte (final_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .fifo_full  (fifo_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    gsm7u_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    gsm7u_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .char_code     (char_code),
        .has_char      (has_char),
        .end_of_message(end_of_message),
        .last_in_run   (last_in_run),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

endmodule
